// ----- sv/sdinit_pkg.sv -----
// Package for the SPI-mode SD card start-up sequencer: codes, constants and types.
package sdinit_pkg;

    // input beat kinds
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_R1    = 2'd1;
    localparam logic [1:0] MODE_TRAIL = 2'd2;

    // result actions
    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_DONE = 2'd2;

    // card types
    localparam logic [2:0] TYPE_ERR  = 3'd0;
    localparam logic [2:0] TYPE_MMC  = 3'd1;
    localparam logic [2:0] TYPE_V1   = 3'd2;
    localparam logic [2:0] TYPE_V2   = 3'd3;
    localparam logic [2:0] TYPE_V2HC = 3'd4;

    // completion status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAIL_R1  = 2'd1;
    localparam logic [1:0] ST_FAIL_OTH = 2'd2;

    // command numbers
    localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0] CMD_SEND_OP      = 6'd1;
    localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
    localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_SD_SEND_OP   = 6'd41;
    localparam logic [5:0] CMD_APP          = 6'd55;
    localparam logic [5:0] CMD_READ_OCR     = 6'd58;

    localparam logic [31:0] ARG_NONE     = 32'h0000_0000;
    localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
    localparam logic [31:0] ARG_BLOCKLEN = 32'd512;

    localparam logic [7:0] CRC_CMD0 = 8'h95;
    localparam logic [7:0] CRC_CMD8 = 8'h87;
    localparam logic [7:0] CRC_NONE = 8'h01;

    localparam logic [7:0] R1_IDLE       = 8'h01;
    localparam logic [7:0] R1_READY      = 8'h00;
    localparam logic [7:0] CHECK_PATTERN = 8'hAA;
    localparam logic [7:0] OCR_CCS_MASK  = 8'h40;
    localparam logic [3:0] START_DUMMIES = 4'd10;

    localparam logic [7:0]  IDLE_LIMIT_RESET  = 8'd20;
    localparam logic [15:0] READY_LIMIT_RESET = 16'hFFFE;

    // register indexes
    localparam logic REG_IDLE_LIMIT  = 1'b0;
    localparam logic REG_READY_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_CMD0     = 4'd1,
        PH_CMD8     = 4'd2,
        PH_R7       = 4'd3,
        PH_55_V2    = 4'd4,
        PH_41_V2    = 4'd5,
        PH_CMD58    = 4'd6,
        PH_OCR      = 4'd7,
        PH_55_PROBE = 4'd8,
        PH_41_PROBE = 4'd9,
        PH_55_V1    = 4'd10,
        PH_41_V1    = 4'd11,
        PH_CMD1     = 4'd12,
        PH_CMD16    = 4'd13
    } phase_t;

    // what one input beat asks the result formatter for
    typedef struct packed {
        logic        emit;
        logic [1:0]  action;
        logic        start;
        logic [5:0]  idx;
        logic [31:0] arg;
        logic        ok;
    } step_req_t;

endpackage

// ----- sv/sd_spi_card_init_sequencer.sv -----
// SPI-mode SD card start-up sequencer: top level with step logic and result register.
//
// Feed the block one beat per card byte: a start request, the R1 reply to the
// last command, or one trailing reply byte (R7 or OCR). For each beat it names
// the next bus action: a command (index, argument, CRC, and 10 leading 0xFF
// bytes on the first CMD0), a request to read one more trailing byte, or a
// finish report with card type, status and the last poll reply. Beats that do
// not fit the current step (an R1 while idle or while trailing bytes are due,
// a trailing byte while an R1 is due, mode 3) give no result. A start beat
// restarts from any step. Rate: one beat per clock cycle sustained while out_ready
// does not hold the result register; each beat passes an input register, the step
// logic, and the result register, which drives the outputs. The sequencer state
// update in the step stage is the one loop that bounds the rate. Retry limits
// live in two APB registers (0x0 CMD0 attempts, 0x4 ACMD41/CMD1 attempts);
// write them only while the block is idle. A limit of 0 acts as 1.
module sd_spi_card_init_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  resp_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [3:0]  dummy_bytes,
    output logic [5:0]  cmd_index,
    output logic [31:0] cmd_arg,
    output logic [7:0]  cmd_crc,
    output logic [2:0]  card_type,
    output logic [1:0]  init_status,
    output logic [7:0]  last_response,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdinit_pkg::*;

    // ---------------- configuration registers ----------------
    logic [7:0]  idle_limit_reg;
    logic [15:0] ready_limit_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg  <= IDLE_LIMIT_RESET;
            ready_limit_reg <= READY_LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_IDLE_LIMIT)
                idle_limit_reg <= pwdata[7:0];
            else
                ready_limit_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_READY_LIMIT)
            prdata = {16'd0, ready_limit_reg};
        else
            prdata = {24'd0, idle_limit_reg};
    end

    // ---------------- input register ----------------
    logic       s1_valid_reg;
    logic [1:0] s1_mode_reg;
    logic [7:0] s1_resp_reg;
    logic       advance;   // step stage may hand its beat on

    assign advance  = !out_valid || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg <= mode;
            s1_resp_reg <= resp_byte;
        end
    end

    // ---------------- sequencer state ----------------
    phase_t      phase_reg, phase_next;
    logic [15:0] retry_count_reg, retry_count_next;
    logic [1:0]  trailing_index_reg, trailing_index_next;
    logic [2:0]  detected_type_reg, detected_type_next;
    logic [7:0]  last_r1_reg, last_r1_next;
    logic [7:0]  trailing_bytes_reg [0:2];   // byte 3 is checked as it arrives
    step_req_t   req;

    // shared terms
    logic [7:0]  r;
    logic [15:0] ready_load;
    logic [15:0] retry_dec;
    logic        idle_retry_ok;
    logic        r7_ok;
    logic        step_en;

    assign r             = s1_resp_reg;
    assign ready_load    = (ready_limit_reg == 16'd0) ? 16'd1 : ready_limit_reg;
    assign retry_dec     = retry_count_reg - 16'd1;
    assign idle_retry_ok = retry_count_reg < {8'd0, idle_limit_reg};
    assign r7_ok         = (trailing_bytes_reg[2] == R1_IDLE) && (r == CHECK_PATTERN);
    assign step_en       = s1_valid_reg && advance;

    // next-state and step request
    always_comb
    begin
        phase_next          = phase_reg;
        retry_count_next    = retry_count_reg;
        trailing_index_next = trailing_index_reg;
        detected_type_next  = detected_type_reg;
        last_r1_next        = last_r1_reg;
        req                 = '0;
        req.action          = ACT_CMD;
        req.idx             = CMD_APP;
        req.arg             = ARG_NONE;

        if (s1_mode_reg == MODE_START)
        begin
            detected_type_next  = TYPE_ERR;
            last_r1_next        = 8'd0;
            trailing_index_next = 2'd0;
            retry_count_next    = 16'd1;
            phase_next          = PH_CMD0;
            req.emit            = 1'b1;
            req.start           = 1'b1;
            req.idx             = CMD_GO_IDLE;
        end
        else if (s1_mode_reg == MODE_TRAIL)
        begin
            if (phase_reg == PH_R7 || phase_reg == PH_OCR)
            begin
                trailing_index_next = trailing_index_reg + 2'd1;
                req.emit            = 1'b1;
                if (trailing_index_reg != 2'd3)
                    req.action = ACT_READ;
                else if (phase_reg == PH_R7)
                begin
                    if (r7_ok)
                    begin
                        retry_count_next = ready_load;
                        phase_next       = PH_55_V2;
                    end
                    else
                        req.action = ACT_DONE;
                end
                else
                begin
                    detected_type_next = ((trailing_bytes_reg[0] & OCR_CCS_MASK) != 8'd0)
                                         ? TYPE_V2HC : TYPE_V2;
                    req.action = ACT_DONE;
                    req.ok     = 1'b1;
                end
            end
        end
        else if (s1_mode_reg == MODE_R1)
        begin
            req.emit = 1'b1;
            case (phase_reg)
                PH_CMD0:
                begin
                    if (r == R1_IDLE)
                    begin
                        phase_next = PH_CMD8;
                        req.idx    = CMD_SEND_IF_COND;
                        req.arg    = ARG_IF_COND;
                    end
                    else if (idle_retry_ok)
                    begin
                        retry_count_next = retry_count_reg + 16'd1;
                        req.idx          = CMD_GO_IDLE;
                    end
                    else
                        req.action = ACT_DONE;
                end
                PH_CMD8:
                begin
                    if (r == R1_IDLE)
                    begin
                        trailing_index_next = 2'd0;
                        phase_next          = PH_R7;
                        req.action          = ACT_READ;
                    end
                    else
                        phase_next = PH_55_PROBE;
                end
                PH_55_V2:
                begin
                    last_r1_next = r;
                    phase_next   = PH_41_V2;
                    req.idx      = CMD_SD_SEND_OP;
                    req.arg      = ARG_HCS;
                end
                PH_41_V2:
                begin
                    last_r1_next     = r;
                    retry_count_next = retry_dec;
                    if (r == R1_READY)
                    begin
                        phase_next = PH_CMD58;
                        req.idx    = CMD_READ_OCR;
                    end
                    else if (retry_dec == 16'd0)
                        req.action = ACT_DONE;
                    else
                        phase_next = PH_55_V2;
                end
                PH_CMD58:
                begin
                    if (r == R1_READY)
                    begin
                        trailing_index_next = 2'd0;
                        phase_next          = PH_OCR;
                        req.action          = ACT_READ;
                    end
                    else
                        req.action = ACT_DONE;
                end
                PH_55_PROBE:
                begin
                    last_r1_next = r;
                    phase_next   = PH_41_PROBE;
                    req.idx      = CMD_SD_SEND_OP;
                end
                PH_41_PROBE:
                begin
                    last_r1_next     = r;
                    retry_count_next = ready_load;
                    if (r <= R1_IDLE)
                    begin
                        detected_type_next = TYPE_V1;
                        phase_next         = PH_55_V1;
                    end
                    else
                    begin
                        detected_type_next = TYPE_MMC;
                        phase_next         = PH_CMD1;
                        req.idx            = CMD_SEND_OP;
                    end
                end
                PH_55_V1:
                begin
                    last_r1_next = r;
                    phase_next   = PH_41_V1;
                    req.idx      = CMD_SD_SEND_OP;
                end
                PH_41_V1, PH_CMD1:
                begin
                    last_r1_next     = r;
                    retry_count_next = retry_dec;
                    if (r == R1_READY)
                    begin
                        phase_next = PH_CMD16;
                        req.idx    = CMD_SET_BLOCKLEN;
                        req.arg    = ARG_BLOCKLEN;
                    end
                    else if (retry_dec == 16'd0)
                        req.action = ACT_DONE;
                    else if (phase_reg == PH_41_V1)
                        phase_next = PH_55_V1;
                    else
                        req.idx = CMD_SEND_OP;
                end
                PH_CMD16:
                begin
                    req.action = ACT_DONE;
                    req.ok     = (r == R1_READY);
                end
                default:
                    req.emit = 1'b0;
            endcase
        end

        // finishing returns to idle; a failure clears the card type
        if (req.emit && req.action == ACT_DONE)
        begin
            phase_next = PH_IDLE;
            if (!req.ok)
                detected_type_next = TYPE_ERR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            retry_count_reg    <= 16'd0;
            trailing_index_reg <= 2'd0;
            detected_type_reg  <= TYPE_ERR;
            last_r1_reg        <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg          <= phase_next;
            retry_count_reg    <= retry_count_next;
            trailing_index_reg <= trailing_index_next;
            detected_type_reg  <= detected_type_next;
            last_r1_reg        <= last_r1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && s1_mode_reg == MODE_TRAIL && trailing_index_reg != 2'd3 &&
            (phase_reg == PH_R7 || phase_reg == PH_OCR))
            trailing_bytes_reg[trailing_index_reg] <= r;
    end

    // ---------------- result formatting ----------------
    logic [1:0]  action_next;
    logic [3:0]  dummy_next;
    logic [5:0]  index_next;
    logic [31:0] arg_next;
    logic [7:0]  crc_next;
    logic [2:0]  type_next;
    logic [1:0]  status_next;
    logic [7:0]  resp_next;

    always_comb
    begin
        action_next = req.action;
        dummy_next  = 4'd0;
        index_next  = 6'd0;
        arg_next    = ARG_NONE;
        crc_next    = 8'd0;
        type_next   = TYPE_ERR;
        status_next = ST_OK;
        resp_next   = 8'd0;
        case (req.action)
            ACT_CMD:
            begin
                dummy_next = req.start ? START_DUMMIES : 4'd0;
                index_next = req.idx;
                arg_next   = req.arg;
                case (req.idx)
                    CMD_GO_IDLE:      crc_next = CRC_CMD0;
                    CMD_SEND_IF_COND: crc_next = CRC_CMD8;
                    default:          crc_next = CRC_NONE;
                endcase
            end
            ACT_DONE:
            begin
                type_next   = detected_type_next;
                resp_next   = last_r1_next;
                if (!req.ok)
                    status_next = (last_r1_next != 8'd0) ? ST_FAIL_R1 : ST_FAIL_OTH;
            end
            default:
                action_next = ACT_READ;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (advance)
            out_valid <= s1_valid_reg && req.emit;
    end

    always_ff @(posedge clk)
    begin
        if (step_en && req.emit)
        begin
            action        <= action_next;
            dummy_bytes   <= dummy_next;
            cmd_index     <= index_next;
            cmd_arg       <= arg_next;
            cmd_crc       <= crc_next;
            card_type     <= type_next;
            init_status   <= status_next;
            last_response <= resp_next;
        end
    end

    // ---------------- assertions ----------------
    a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    a_trail_index_in_trailing_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (trailing_index_reg != 2'd0) |-> (phase_reg == PH_R7 || phase_reg == PH_OCR))
        else $error("trailing byte count left set outside a trailing phase");

    a_fail_has_error_type: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action == ACT_DONE && init_status != ST_OK) |-> (card_type == TYPE_ERR))
        else $error("failed finish reports a card type");

    a_dummies_only_on_cmd0: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dummy_bytes != 4'd0) |-> (action == ACT_CMD && cmd_index == CMD_GO_IDLE))
        else $error("leading dummy bytes on a command other than CMD0");

    a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && req.emit && req.action == ACT_DONE) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after finish");

endmodule
